FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the edit distance checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, off while reset is high
`define SGED_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sged assertion failed");

// implication into the next cycle, watched through reset as well
`define SGED_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sged assertion failed");

`endif

FILE: sv/sged_pkg.sv
// ----------------------------------------------------------------------------
// sged_pkg
// command codes, symbol codes and the control word carried along the cell row
// ----------------------------------------------------------------------------
package sged_pkg;

  // command codes on func
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_TEXT   = 2'd1;
  localparam logic [1:0] FUNC_REPORT = 2'd2;

  // ascii symbols
  localparam logic [7:0] CH_A_UP = 8'h41;
  localparam logic [7:0] CH_C_UP = 8'h43;
  localparam logic [7:0] CH_G_UP = 8'h47;
  localparam logic [7:0] CH_T_UP = 8'h54;
  localparam logic [7:0] CH_A_LO = 8'h61;
  localparam logic [7:0] CH_C_LO = 8'h63;
  localparam logic [7:0] CH_G_LO = 8'h67;
  localparam logic [7:0] CH_T_LO = 8'h74;
  localparam logic [7:0] CH_N    = 8'h4e;
  localparam logic [7:0] CH_STAR = 8'h2a;
  localparam logic [7:0] CH_QUES = 8'h3f;

  typedef enum logic [1:0] {
    TOK_LOAD,
    TOK_TEXT,
    TOK_REPORT
  } tok_kind_t;

  // control word that walks the cell row with each item
  typedef struct packed {
    logic       valid;
    tok_kind_t  kind;
    logic       init;   // reset columns to 0..length
    logic       write;  // pattern symbol is stored
    logic [7:0] sym;    // text or pattern symbol
    logic [7:0] comp;   // complemented text symbol
    logic [7:0] rsh;    // reversed pattern shifting one cell right
  } tok_ctl_t;

  function automatic logic [7:0] complement(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      CH_A_UP: r = CH_T_UP;
      CH_T_UP: r = CH_A_UP;
      CH_G_UP: r = CH_C_UP;
      CH_C_UP: r = CH_G_UP;
      CH_A_LO: r = CH_T_LO;
      CH_T_LO: r = CH_A_LO;
      CH_G_LO: r = CH_C_LO;
      CH_C_LO: r = CH_G_LO;
      CH_N:    r = CH_N;
      CH_STAR: r = CH_STAR;
      default: r = CH_QUES;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/sged_head.sv
// ----------------------------------------------------------------------------
// sged_head
// intake: tracks pattern length and seal, turns items into row control words
// ----------------------------------------------------------------------------
module sged_head #(
  parameter int MAX_PATTERN = 256,
  parameter int VW          = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [1:0]         func,
  input  logic [7:0]         symbol,
  input  logic               last,
  output sged_pkg::tok_ctl_t ctl_out,
  output logic [VW-1:0]      len_out
);

  localparam logic [VW-1:0] LIMIT = VW'(MAX_PATTERN);

  logic [VW-1:0]      plen;
  logic [VW-1:0]      plen_next;
  logic               sealed;
  logic               sealed_next;
  logic [VW-1:0]      base;
  logic [VW-1:0]      grown;
  logic               can_write;
  logic [VW-1:0]      len_next;
  sged_pkg::tok_ctl_t ctl_next;

  always_comb begin
    // a load after a seal starts a fresh pattern
    base        = sealed ? '0 : plen;
    can_write   = (base < LIMIT);
    grown       = can_write ? base + VW'(1) : base;
    plen_next   = plen;
    sealed_next = sealed;
    len_next    = plen;
    ctl_next      = '0;
    ctl_next.sym  = symbol;
    ctl_next.comp = sged_pkg::complement(symbol);
    ctl_next.rsh  = symbol;
    if (accept) begin
      unique case (func)
        sged_pkg::FUNC_LOAD: begin
          ctl_next.valid = 1'b1;
          ctl_next.kind  = sged_pkg::TOK_LOAD;
          ctl_next.write = can_write;
          ctl_next.init  = last;
          plen_next      = grown;
          sealed_next    = last;
          len_next       = grown;
        end
        sged_pkg::FUNC_TEXT: begin
          ctl_next.valid = sealed;
          ctl_next.kind  = sged_pkg::TOK_TEXT;
        end
        sged_pkg::FUNC_REPORT: begin
          ctl_next.valid = 1'b1;
          ctl_next.kind  = sged_pkg::TOK_REPORT;
          ctl_next.init  = sealed;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen    <= '0;
      sealed  <= 1'b0;
      ctl_out <= '0;
    end else begin
      plen    <= plen_next;
      sealed  <= sealed_next;
      ctl_out <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    len_out <= len_next;
  end

endmodule

FILE: sv/sged_cell.sv
// ----------------------------------------------------------------------------
// sged_cell
// one pattern position: holds both strands' symbols and column entries
// ----------------------------------------------------------------------------
module sged_cell #(
  parameter int VW  = 9,
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  sged_pkg::tok_ctl_t ctl_in,
  input  logic [VW-1:0]      len_in,
  input  logic [VW-1:0]      fnew_in,
  input  logic [VW-1:0]      fdiag_in,
  input  logic [VW-1:0]      rnew_in,
  input  logic [VW-1:0]      rdiag_in,
  input  logic [VW-1:0]      fres_in,
  input  logic [VW-1:0]      rres_in,
  output sged_pkg::tok_ctl_t ctl_out,
  output logic [VW-1:0]      len_out,
  output logic [VW-1:0]      fnew_out,
  output logic [VW-1:0]      fdiag_out,
  output logic [VW-1:0]      rnew_out,
  output logic [VW-1:0]      rdiag_out,
  output logic [VW-1:0]      fres_out,
  output logic [VW-1:0]      rres_out
);

  // row index of this cell's column entry, also its value after init
  localparam logic [VW-1:0] POS = VW'(IDX + 1);

  logic [7:0]         fsym;
  logic [7:0]         rsym;
  logic [VW-1:0]      fval;
  logic [VW-1:0]      rval;
  logic [VW-1:0]      fcalc;
  logic [VW-1:0]      rcalc;
  logic               is_end;
  sged_pkg::tok_ctl_t ctl_next;

  function automatic logic [VW-1:0] cell_step(
    input logic [VW-1:0] up,
    input logic [VW-1:0] left,
    input logic [VW-1:0] diag,
    input logic          miss
  );
    logic [VW:0] a;
    logic [VW:0] b;
    logic [VW:0] c;
    logic [VW:0] m;
    a = {1'b0, up} + (VW+1)'(1);
    b = {1'b0, left} + (VW+1)'(1);
    c = {1'b0, diag} + (VW+1)'(miss);
    m = (a < b) ? a : b;
    m = (m < c) ? m : c;
    return m[VW-1:0];
  endfunction

  assign is_end = (len_in == POS);
  assign fcalc  = cell_step(fval, fnew_in, fdiag_in, fsym != ctl_in.sym);
  assign rcalc  = cell_step(rval, rnew_in, rdiag_in, rsym != ctl_in.comp);

  always_comb begin
    ctl_next     = ctl_in;
    ctl_next.rsh = rsym;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_next;
    end
  end

  // cell contents, only touched by valid control words
  always_ff @(posedge clk) begin
    if (ctl_in.valid) begin
      unique case (ctl_in.kind)
        sged_pkg::TOK_LOAD: begin
          if (ctl_in.write) begin
            rsym <= ctl_in.rsh;
            if (is_end) begin
              fsym <= ctl_in.sym;
            end
          end
          if (ctl_in.init) begin
            fval <= POS;
            rval <= POS;
          end
        end
        sged_pkg::TOK_TEXT: begin
          fval <= fcalc;
          rval <= rcalc;
        end
        sged_pkg::TOK_REPORT: begin
          if (ctl_in.init) begin
            fval <= POS;
            rval <= POS;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    len_out   <= len_in;
    fnew_out  <= fcalc;
    fdiag_out <= fval;
    rnew_out  <= rcalc;
    rdiag_out <= rval;
    fres_out  <= is_end ? fcalc : fres_in;
    rres_out  <= is_end ? rcalc : rres_in;
  end

endmodule

FILE: sv/sged_tail.sv
// ----------------------------------------------------------------------------
// sged_tail
// keeps the best bottom entry of each strand and drives the report
// ----------------------------------------------------------------------------
module sged_tail #(
  parameter int VW = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  sged_pkg::tok_ctl_t ctl_in,
  input  logic [VW-1:0]      len_in,
  input  logic [VW-1:0]      fres_in,
  input  logic [VW-1:0]      rres_in,
  output logic               done,
  output logic [8:0]         distance
);

  logic [VW-1:0] best_fwd;
  logic [VW-1:0] best_rev;
  logic [VW-1:0] best_min;
  logic [VW+8:0] best_wide;

  assign best_min  = (best_fwd < best_rev) ? best_fwd : best_rev;
  assign best_wide = {9'b0, best_min};

  always_ff @(posedge clk) begin
    if (rst) begin
      best_fwd <= '0;
      best_rev <= '0;
      done     <= 1'b0;
    end else begin
      done <= ctl_in.valid && (ctl_in.kind == sged_pkg::TOK_REPORT);
      if (ctl_in.valid) begin
        unique case (ctl_in.kind)
          sged_pkg::TOK_LOAD: begin
            if (ctl_in.init) begin
              best_fwd <= len_in;
              best_rev <= len_in;
            end
          end
          sged_pkg::TOK_TEXT: begin
            if (fres_in < best_fwd) begin
              best_fwd <= fres_in;
            end
            if (rres_in < best_rev) begin
              best_rev <= rres_in;
            end
          end
          sged_pkg::TOK_REPORT: begin
            if (ctl_in.init) begin
              best_fwd <= len_in;
              best_rev <= len_in;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.valid && (ctl_in.kind == sged_pkg::TOK_REPORT)) begin
      distance <= best_wide[8:0];
    end
  end

endmodule

FILE: sv/semi_global_edit_distance_both_strands_unit.sv
// ----------------------------------------------------------------------------
// semi_global_edit_distance_both_strands_unit
// unit-cost semi-global edit distance of a loaded dna pattern against a
// streamed text, on the forward and the reverse-complement strand at once
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload                  direction
//  command   start / busy       func, symbol, last       in
//  result    done (strobe)      distance                 out
//
//  one item is taken every cycle; busy is high only while rst is high
//  every item walks a row of MAX_PATTERN cells, one cell per cycle: a report
//  is held in the intake register, then in the register of each cell in turn,
//  and last in the result register, which raises done and loads distance
//  items keep their order through the row, so loads, text and reports may
//  follow each other back to back with no gaps
//  rst clears the length, the seal, the bests and every in-flight item
//  done is high for one cycle per report and cannot be held off
//
module semi_global_edit_distance_both_strands_unit #(
  parameter int MAX_PATTERN = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] func,
  input  logic [7:0] symbol,
  input  logic       last,
  output logic       done,
  output logic [8:0] distance
);

  // column entries never exceed MAX_PATTERN
  localparam int VW = $clog2(MAX_PATTERN + 1);

  // one slot per hop: slot 0 feeds the first cell, the last slot the tail
  sged_pkg::tok_ctl_t ctl_c   [MAX_PATTERN+1];
  logic [VW-1:0]      len_c   [MAX_PATTERN+1];
  logic [VW-1:0]      fnew_c  [MAX_PATTERN+1];
  logic [VW-1:0]      fdiag_c [MAX_PATTERN+1];
  logic [VW-1:0]      rnew_c  [MAX_PATTERN+1];
  logic [VW-1:0]      rdiag_c [MAX_PATTERN+1];
  logic [VW-1:0]      fres_c  [MAX_PATTERN+1];
  logic [VW-1:0]      rres_c  [MAX_PATTERN+1];
  logic               accept;

  // no backpressure apart from reset
  assign busy   = rst;
  assign accept = start && !busy;

  // top row of both columns is always zero (free start anywhere in the text)
  assign fnew_c[0]  = '0;
  assign fdiag_c[0] = '0;
  assign rnew_c[0]  = '0;
  assign rdiag_c[0] = '0;
  assign fres_c[0]  = '0;
  assign rres_c[0]  = '0;

  // intake: pattern length, seal, complement of text symbols
  sged_head #(
    .MAX_PATTERN (MAX_PATTERN),
    .VW          (VW)
  ) u_head (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .func    (func),
    .symbol  (symbol),
    .last    (last),
    .ctl_out (ctl_c[0]),
    .len_out (len_c[0])
  );

  // cell g holds pattern[g] for the forward strand and pattern[len-1-g] for
  // the reverse strand, plus row g+1 of each column; the bottom entry rides
  // along to the tail from the cell whose row equals the pattern length
  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    sged_cell #(
      .VW  (VW),
      .IDX (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl_in    (ctl_c[g]),
      .len_in    (len_c[g]),
      .fnew_in   (fnew_c[g]),
      .fdiag_in  (fdiag_c[g]),
      .rnew_in   (rnew_c[g]),
      .rdiag_in  (rdiag_c[g]),
      .fres_in   (fres_c[g]),
      .rres_in   (rres_c[g]),
      .ctl_out   (ctl_c[g+1]),
      .len_out   (len_c[g+1]),
      .fnew_out  (fnew_c[g+1]),
      .fdiag_out (fdiag_c[g+1]),
      .rnew_out  (rnew_c[g+1]),
      .rdiag_out (rdiag_c[g+1]),
      .fres_out  (fres_c[g+1]),
      .rres_out  (rres_c[g+1])
    );
  end

  // bests per strand and the report strobe
  sged_tail #(
    .VW (VW)
  ) u_tail (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (ctl_c[MAX_PATTERN]),
    .len_in   (len_c[MAX_PATTERN]),
    .fres_in  (fres_c[MAX_PATTERN]),
    .rres_in  (rres_c[MAX_PATTERN]),
    .done     (done),
    .distance (distance)
  );

endmodule

FILE: sv/sged_checker.sv
// ----------------------------------------------------------------------------
// sged_checker
// port-level checks on report timing and result range
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sged_checker #(
  parameter int MAX_PATTERN = 256
) (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] func,
  input logic       done,
  input logic [8:0] distance
);

  localparam int LAT = MAX_PATTERN + 2;

  logic take_report;

  assign take_report = start && !busy && (func == sged_pkg::FUNC_REPORT);

  `SGED_ASSERT_IMP(a_report_gives_result, clk, rst, take_report, ##LAT done)
  `SGED_ASSERT_IMP(a_result_from_report, clk, rst, done, $past(take_report, LAT))
  `SGED_ASSERT_IMP(a_distance_range, clk, rst, done, 32'(distance) <= 32'(MAX_PATTERN))
  `SGED_ASSERT_NEXT(a_quiet_after_reset, clk, rst, !done)

endmodule

bind semi_global_edit_distance_both_strands_unit sged_checker #(
  .MAX_PATTERN (MAX_PATTERN)
) u_sged_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .func     (func),
  .done     (done),
  .distance (distance)
);

FILE: bench/semi_global_edit_distance_both_strands_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semi_global_edit_distance_both_strands_unit_test
// self-checking bench for the both-strand semi-global edit distance unit
// a short directed table covers reset, unused codes, the full pattern store,
// new loads and the reverse strand; random load/text/report sequences follow
// every accepted item runs through an in-bench alignment predictor and each
// distance on done is compared with the oldest pending expected distance,
// either predicted or typed into the directed table
module semi_global_edit_distance_both_strands_unit_test;

  localparam int MAX_PAT = 256;
  localparam int LATENCY = MAX_PAT + 2;    // intake, cell row, result register
  localparam int QUIET_LIMIT = 2000;       // cycles with no item and no result
  localparam int ITEM_TARGET = 900;        // item count at which the random part stops
  localparam logic [1:0] FUNC_NOP = 2'd3;  // unused command code

  // one directed row: an item, how often it repeats, and an optional
  // distance that is typed in instead of predicted
  typedef struct packed {
    logic [1:0] fn;
    logic [7:0] sym;
    logic       lst;
    logic [9:0] reps;
    logic       pinned;
    logic [8:0] exp_dist;
  } stim_row_t;

  // dut signals; the driven ones are known from time zero
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [1:0] func = FUNC_NOP;
  logic [7:0] symbol = 8'h00;
  logic       last = 1'b0;
  logic       busy;
  logic       done;
  logic [8:0] distance;

  // typed expectation that travels with the item on the command port
  logic       pin_on = 1'b0;
  logic [8:0] pin_dist = 9'd0;

  // alignment predictor state
  logic [7:0]  pat_mem [MAX_PAT];
  int unsigned pat_len;
  int unsigned dp_col [2][MAX_PAT+1];   // index 0 forward, 1 reverse strand
  int unsigned best [2];
  bit          pat_sealed;

  logic [8:0] pending_distances [$];
  stim_row_t  directed_rows [$];

  int  errors;
  int  items_taken;
  int  distances_checked;
  int  items_sent;
  int  seq_count;
  int  max_plen;
  int  quiet;
  bit  no_idle;

  semi_global_edit_distance_both_strands_unit #(
    .MAX_PATTERN(MAX_PAT)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .func    (func),
    .symbol  (symbol),
    .last    (last),
    .done    (done),
    .distance(distance)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // strand complement: upper and lower case bases swap, n and star stay,
  // anything else turns into a question mark
  function automatic logic [7:0] dna_complement(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      sged_pkg::CH_A_UP: r = sged_pkg::CH_T_UP;
      sged_pkg::CH_T_UP: r = sged_pkg::CH_A_UP;
      sged_pkg::CH_G_UP: r = sged_pkg::CH_C_UP;
      sged_pkg::CH_C_UP: r = sged_pkg::CH_G_UP;
      sged_pkg::CH_A_LO: r = sged_pkg::CH_T_LO;
      sged_pkg::CH_T_LO: r = sged_pkg::CH_A_LO;
      sged_pkg::CH_G_LO: r = sged_pkg::CH_C_LO;
      sged_pkg::CH_C_LO: r = sged_pkg::CH_G_LO;
      sged_pkg::CH_N:    r = sged_pkg::CH_N;
      sged_pkg::CH_STAR: r = sged_pkg::CH_STAR;
      default:           r = sged_pkg::CH_QUES;
    endcase
    return r;
  endfunction

  // both columns back to 0..length, both bests back to the length
  function void reset_columns();
    int j;
    for (j = 0; j <= pat_len; j++) begin
      dp_col[0][j] = j;
      dp_col[1][j] = j;
    end
    best[0] = pat_len;
    best[1] = pat_len;
  endfunction

  // applies one accepted item to the predictor; a report yields a distance
  task automatic advance_alignment(input logic [1:0] fn, input logic [7:0] sym,
                                   input logic lst, output bit has_dist,
                                   output logic [8:0] res_dist);
    int unsigned diag;
    int unsigned up;
    int unsigned cand;
    int unsigned cost;
    int          s;
    int          j;
    int          idx;
    logic [7:0]  t;
    has_dist = 1'b0;
    res_dist = 9'd0;
    case (fn)
      sged_pkg::FUNC_LOAD: begin
        // a load after a seal starts a fresh pattern
        if (pat_sealed) begin
          pat_sealed = 1'b0;
          pat_len = 0;
        end
        // symbols past a full store are dropped, but last still seals
        if (pat_len < MAX_PAT) begin
          pat_mem[pat_len] = sym;
          pat_len++;
        end
        if (lst) begin
          pat_sealed = 1'b1;
          reset_columns();
        end
      end
      sged_pkg::FUNC_TEXT: begin
        // text is ignored until a pattern is sealed
        if (pat_sealed) begin
          for (s = 0; s < 2; s++) begin
            t = (s == 1) ? dna_complement(sym) : sym;
            diag = dp_col[s][0];
            dp_col[s][0] = 0;   // free start anywhere in the text
            for (j = 0; j < pat_len; j++) begin
              idx = (s == 1) ? (pat_len - 1 - j) : j;
              cost = (pat_mem[idx] == t) ? 0 : 1;
              up = dp_col[s][j+1];
              cand = up + 1;
              if (dp_col[s][j] + 1 < cand) cand = dp_col[s][j] + 1;
              if (diag + cost < cand) cand = diag + cost;
              dp_col[s][j+1] = cand;
              diag = up;
            end
            if (dp_col[s][pat_len] < best[s]) best[s] = dp_col[s][pat_len];
          end
        end
      end
      sged_pkg::FUNC_REPORT: begin
        has_dist = 1'b1;
        res_dist = (best[0] < best[1]) ? best[0][8:0] : best[1][8:0];
        // a sealed pattern is rearmed for the next text
        if (pat_sealed) reset_columns();
      end
      default: begin
      end
    endcase
  endtask

  // idle gaps: mostly none or short, now and then a long one
  function automatic int idle_cycles();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 200);
  endfunction

  // mostly dna bases, some lower case, n, star and raw bytes
  function automatic logic [7:0] pick_symbol();
    int r;
    r = $urandom_range(0, 99);
    case (1'b1)
      (r < 70): begin
        case ($urandom_range(0, 3))
          0: return sged_pkg::CH_A_UP;
          1: return sged_pkg::CH_C_UP;
          2: return sged_pkg::CH_G_UP;
          default: return sged_pkg::CH_T_UP;
        endcase
      end
      (r < 80): begin
        case ($urandom_range(0, 3))
          0: return sged_pkg::CH_A_LO;
          1: return sged_pkg::CH_C_LO;
          2: return sged_pkg::CH_G_LO;
          default: return sged_pkg::CH_T_LO;
        endcase
      end
      (r < 85): return sged_pkg::CH_N;
      (r < 88): return sged_pkg::CH_STAR;
      default: return 8'($urandom);
    endcase
  endfunction

  // appends one row to the directed table
  function automatic void add_row(input logic [1:0] fn, input logic [7:0] sym,
                                  input logic lst, input int reps,
                                  input logic pinned, input int exp_dist);
    stim_row_t r;
    r.fn = fn;
    r.sym = sym;
    r.lst = lst;
    r.reps = reps[9:0];
    r.pinned = pinned;
    r.exp_dist = exp_dist[8:0];
    directed_rows = {directed_rows, r};
  endfunction

  // presents one item, holds it until taken, then maybe idles with junk
  // on the payload; start is only ever assigned once per time step
  task automatic send_item(input logic [1:0] fn, input logic [7:0] sym,
                           input logic lst, input logic pinned,
                           input logic [8:0] pdist);
    int gap;
    start    <= 1'b1;
    func     <= fn;
    symbol   <= sym;
    last     <= lst;
    pin_on   <= pinned;
    pin_dist <= pdist;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = idle_cycles();
    if (gap > 0) begin
      start  <= 1'b0;
      pin_on <= 1'b0;
      func   <= 2'($urandom);
      symbol <= 8'($urandom);
      last   <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // result check, item intake and the watchdog, all at one edge so that
  // the order of events inside a time step does not matter
  always @(posedge clk) begin : monitor
    bit         has_dist;
    logic [8:0] pred;
    logic [8:0] want;
    bit         progress;
    if (rst) begin
      quiet = 0;
    end else begin
      progress = 1'b0;
      // a result first, its item left long ago
      if (done) begin
        progress = 1'b1;
        if (pending_distances.size() == 0) begin
          if (errors < 10)
            $display("unexpected distance %0d with no report pending", distance);
          errors++;
        end else begin
          want = pending_distances.pop_front();
          distances_checked++;
          if (distance !== want) begin
            if (errors < 10)
              $display("distance mismatch: expected %0d, got %0d", want, distance);
            errors++;
          end
        end
      end
      // then the item taken at this edge
      if (start && !busy) begin
        progress = 1'b1;
        items_taken++;
        advance_alignment(func, symbol, last, has_dist, pred);
        if (has_dist) pending_distances = {pending_distances, pin_on ? pin_dist : pred};
      end
      quiet = progress ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: %0d cycles without an item or a result", quiet);
        $display("semi_global_edit_distance_both_strands_unit_test NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] pbuf [300];
    logic [7:0] tbuf [$];
    logic [1:0] fn;
    logic [7:0] c;
    int         plen;
    int         mode;
    int         r;
    int         i;

    // directed table
    // report straight out of reset gives zero
    add_row(sged_pkg::FUNC_REPORT, 8'h00, 1'b0, 1, 1'b1, 0);
    // text with no sealed pattern is ignored
    add_row(sged_pkg::FUNC_TEXT, sged_pkg::CH_A_UP, 1'b0, 1, 1'b0, 0);
    // unused code does nothing
    add_row(FUNC_NOP, 8'hff, 1'b1, 1, 1'b0, 0);
    // symbol and last are don't-care on a report
    add_row(sged_pkg::FUNC_REPORT, 8'hff, 1'b1, 1, 1'b1, 0);
    // pattern acgt, sealed on the last symbol
    add_row(sged_pkg::FUNC_LOAD, sged_pkg::CH_A_UP, 1'b0, 1, 1'b0, 0);
    add_row(sged_pkg::FUNC_LOAD, sged_pkg::CH_C_UP, 1'b0, 1, 1'b0, 0);
    add_row(sged_pkg::FUNC_LOAD, sged_pkg::CH_G_UP, 1'b0, 1, 1'b0, 0);
    add_row(sged_pkg::FUNC_LOAD, sged_pkg::CH_T_UP, 1'b1, 1, 1'b0, 0);
    // no text yet: both bests sit at the pattern length
    add_row(sged_pkg::FUNC_REPORT, 8'h00, 1'b0, 1, 1'b1, 4);
    // exact forward hit
    add_row(sged_pkg::FUNC_TEXT, sged_pkg::CH_A_UP, 1'b0, 1, 1'b0, 0);
    add_row(sged_pkg::FUNC_TEXT, sged_pkg::CH_C_UP, 1'b1, 1, 1'b0, 0);
    add_row(sged_pkg::FUNC_TEXT, sged_pkg::CH_G_UP, 1'b0, 1, 1'b0, 0);
    add_row(sged_pkg::FUNC_TEXT, sged_pkg::CH_T_UP, 1'b0, 1, 1'b0, 0);
    add_row(sged_pkg::FUNC_REPORT, 8'h00, 1'b0, 1, 1'b1, 0);
    // n, and a byte that complements to a question mark
    add_row(sged_pkg::FUNC_TEXT, sged_pkg::CH_N, 1'b0, 1, 1'b0, 0);
    add_row(sged_pkg::FUNC_TEXT, 8'h80, 1'b1, 1, 1'b0, 0);
    add_row(sged_pkg::FUNC_REPORT, 8'h00, 1'b0, 1, 1'b0, 0);
    // overfill the store; the dropped last symbol still seals
    add_row(sged_pkg::FUNC_LOAD, 8'hff, 1'b0, 300, 1'b0, 0);
    add_row(sged_pkg::FUNC_LOAD, 8'h00, 1'b1, 1, 1'b0, 0);
    add_row(sged_pkg::FUNC_REPORT, 8'h00, 1'b0, 1, 1'b1, MAX_PAT);
    // new load over a sealed pattern: aac
    add_row(sged_pkg::FUNC_LOAD, sged_pkg::CH_A_UP, 1'b0, 2, 1'b0, 0);
    add_row(sged_pkg::FUNC_LOAD, sged_pkg::CH_C_UP, 1'b1, 1, 1'b0, 0);
    // gtt is the reverse complement of aac, a hit on the reverse strand
    add_row(sged_pkg::FUNC_TEXT, sged_pkg::CH_G_UP, 1'b0, 1, 1'b0, 0);
    add_row(sged_pkg::FUNC_TEXT, sged_pkg::CH_T_UP, 1'b0, 2, 1'b0, 0);
    add_row(sged_pkg::FUNC_REPORT, 8'h00, 1'b0, 1, 1'b1, 0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      repeat (directed_rows[k].reps)
        send_item(directed_rows[k].fn, directed_rows[k].sym, directed_rows[k].lst,
                  directed_rows[k].pinned, directed_rows[k].exp_dist);
      items_sent += int'(directed_rows[k].reps);
    end

    // random part: mostly whole load/text/report sequences
    while (items_sent < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 85) begin
        seq_count++;
        // mostly short patterns, a few near or past the store size
        r = $urandom_range(0, 99);
        if (r < 82) plen = $urandom_range(1, 12);
        else if (r < 97) plen = $urandom_range(13, 40);
        else plen = $urandom_range(240, 262);
        if (plen > max_plen) max_plen = plen;
        for (i = 0; i < plen; i++) begin
          pbuf[i] = pick_symbol();
          if ($urandom_range(0, 49) == 0)
            send_item(FUNC_NOP, 8'($urandom), 1'($urandom), 1'b0, 9'd0);
          send_item(sged_pkg::FUNC_LOAD, pbuf[i], (i == plen - 1), 1'b0, 9'd0);
        end
        items_sent += plen;

        // text: random, or the pattern / its reverse complement with edits
        mode = $urandom_range(0, 2);
        tbuf.delete();
        if (mode == 0) begin
          repeat ($urandom_range(0, 30)) tbuf = {tbuf, pick_symbol()};
        end else begin
          repeat ($urandom_range(0, 5)) tbuf = {tbuf, pick_symbol()};
          for (i = 0; i < plen; i++) begin
            c = (mode == 1) ? pbuf[i] : dna_complement(pbuf[plen-1-i]);
            r = $urandom_range(0, 99);
            if (r < 7) begin
              // deletion
            end else if (r < 14) begin
              tbuf = {tbuf, pick_symbol()};
            end else begin
              if (r < 20) tbuf = {tbuf, pick_symbol()};
              tbuf = {tbuf, c};
            end
          end
          repeat ($urandom_range(0, 5)) tbuf = {tbuf, pick_symbol()};
        end
        foreach (tbuf[k]) begin
          if ($urandom_range(0, 39) == 0)
            send_item(FUNC_NOP, 8'($urandom), 1'($urandom), 1'b0, 9'd0);
          send_item(sged_pkg::FUNC_TEXT, tbuf[k], 1'($urandom), 1'b0, 9'd0);
        end
        items_sent += tbuf.size();

        // report, sometimes twice to see the rearm
        send_item(sged_pkg::FUNC_REPORT, 8'($urandom), 1'($urandom), 1'b0, 9'd0);
        items_sent++;
        if ($urandom_range(0, 4) == 0) begin
          send_item(sged_pkg::FUNC_REPORT, 8'($urandom), 1'($urandom), 1'b0, 9'd0);
          items_sent++;
        end
      end else begin
        // noise: any code, any symbol, any last
        repeat ($urandom_range(1, 6)) begin
          fn = 2'($urandom_range(0, 3));
          send_item(fn, 8'($urandom), 1'($urandom), 1'b0, 9'd0);
          if (fn != FUNC_NOP) items_sent++;
        end
      end
    end

    start  <= 1'b0;
    pin_on <= 1'b0;

    // drain, then give a stray done time to show up
    while (pending_distances.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("%0d items taken, %0d distances checked, %0d random sequences",
             items_taken, distances_checked, seq_count);
    $display("patterns up to %0d symbols, store overflow, both strands, %0d errors",
             max_plen, errors);
    if (errors == 0) begin
      $display("semi_global_edit_distance_both_strands_unit_test OK");
    end else begin
      $display("semi_global_edit_distance_both_strands_unit_test NOT OK");
    end
    $finish;
  end

endmodule
